// ----- hdl/dip_pkg.sv -----
// package for the decimal integer parser: payload types, codes and constants
package dip_pkg;

    localparam int CP_BITS            = 21;
    localparam int VALUE_BITS         = 64;
    localparam int STATUS_BITS        = 2;
    localparam int COUNT_OUT_BITS     = 16;
    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int CFG_INDEX_BITS     = 8;
    localparam int CFG_DATA_BITS      = 8;
    localparam int WIDTH_CODE_BITS    = 2;

    // code points that steer the parse
    localparam logic [CP_BITS-1:0] CP_PLUS  = 21'h00002B;
    localparam logic [CP_BITS-1:0] CP_MINUS = 21'h00002D;
    localparam logic [CP_BITS-1:0] CP_ZERO  = 21'h000030;
    localparam logic [CP_BITS-1:0] CP_NINE  = 21'h000039;

    // parse phases
    localparam logic [1:0] PHASE_START  = 2'd0;
    localparam logic [1:0] PHASE_SIGN   = 2'd1;
    localparam logic [1:0] PHASE_DIGITS = 2'd2;

    // result status codes
    localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_NO_DIGITS = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_RANGE     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_RESULT_WIDTH_CODE = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RESULT_IS_SIGNED  = 8'd1;

    // result width codes
    localparam logic [WIDTH_CODE_BITS-1:0] WIDTH_8  = 2'd0;
    localparam logic [WIDTH_CODE_BITS-1:0] WIDTH_16 = 2'd1;
    localparam logic [WIDTH_CODE_BITS-1:0] WIDTH_32 = 2'd2;
    localparam logic [WIDTH_CODE_BITS-1:0] WIDTH_64 = 2'd3;

    typedef struct packed {
        logic [CP_BITS-1:0] char_code;
        logic               end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0]     value_bits;
        logic [STATUS_BITS-1:0]    status;
        logic [COUNT_OUT_BITS-1:0] consumed_count;
        logic [CP_BITS-1:0]        terminator;
        logic                      ended_by_input_end;
    } out_item_t;

endpackage

// ----- hdl/decimal_integer_parser.sv -----
// decimal integer parser: sign and ascii digits in, checked integer result out
//
// usage
//   s_valid/s_ready/s_data carry one code point per transfer, or an end of
//   input marker. m_valid/m_ready/m_data carry one result per closed number.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the result width code
//   (index 0) and the signed flag (index 1); cfg_ready is always high and
//   writes to other indexes are dropped. write configuration only when idle.
//   a number is closed by the first code point that cannot extend it or by
//   end of input; the closing code point is reported as the terminator and
//   is not counted, and the next transfer starts a new number.
// timing
//   an input transfer is registered, then handled from the input register by
//   one multiply-by-ten-and-add with its range compare; a closing item puts
//   its result in the output register, which drives m_valid. one item per
//   cycle is taken unless a closing item waits for the output slot.
// reset and stalls
//   synchronous active low reset empties both stages, clears the parse state
//   and returns the registers to 32-bit signed. while m_ready is low a
//   waiting result holds; items that do not close a number keep flowing, and
//   a closing item waits in the input register until the output slot frees.
module decimal_integer_parser #(
    parameter int COUNT_BITS = dip_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  dip_pkg::in_item_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output dip_pkg::out_item_t                 m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dip_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dip_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import dip_pkg::*;

    localparam int WIDE_BITS = VALUE_BITS + 4;

    // configuration registers
    logic [WIDTH_CODE_BITS-1:0] width_code_reg;
    logic                       is_signed_reg;

    // input stage
    logic     in_valid_reg;
    in_item_t in_data_reg;

    // parse state
    logic [1:0]            phase_reg,     phase_next;
    logic                  minus_reg,     minus_next;
    logic [VALUE_BITS-1:0] magnitude_reg, magnitude_next;
    logic                  overflow_reg,  overflow_next;
    logic [COUNT_BITS-1:0] consumed_reg,  consumed_next;

    // output stage
    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t out_data_next;

    // item classification
    logic                  eoi;
    logic [CP_BITS-1:0]    cp;
    logic [3:0]            cp_offset;
    logic                  is_digit;
    logic                  is_sign;
    logic                  closes;
    logic                  take_item;
    logic                  out_free;

    // digit accumulate
    logic [WIDE_BITS-1:0]  mag_wide;
    logic [WIDE_BITS-1:0]  scaled;
    logic                  step_overflow;
    logic [COUNT_BITS-1:0] consumed_bumped;

    // range check at close
    logic [VALUE_BITS-1:0]  umax;
    logic [VALUE_BITS-1:0]  smax;
    logic [STATUS_BITS-1:0] status;
    logic [VALUE_BITS-1:0]  value;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_code_reg <= WIDTH_32;
            is_signed_reg  <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_RESULT_WIDTH_CODE: width_code_reg <= cfg_data[WIDTH_CODE_BITS-1:0];
                REG_RESULT_IS_SIGNED:  is_signed_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // classify the registered item
    always_comb begin
        eoi       = in_data_reg.end_of_input;
        cp        = in_data_reg.char_code;
        cp_offset = cp[3:0] - CP_ZERO[3:0];
        is_digit  = !eoi && (cp >= CP_ZERO) && (cp <= CP_NINE);
        is_sign   = !eoi && (phase_reg == PHASE_START)
                    && ((cp == CP_PLUS) || (cp == CP_MINUS));
        closes    = !is_digit && !is_sign;
    end

    // output slot frees when empty or taken this cycle
    assign out_free  = !out_valid_reg || m_ready;
    assign take_item = in_valid_reg && (!closes || out_free);
    assign s_ready   = !in_valid_reg || take_item;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    // magnitude * 10 + digit, with carry out into the top nibble
    always_comb begin
        mag_wide      = {4'd0, magnitude_reg};
        scaled        = (mag_wide << 3) + (mag_wide << 1)
                        + {{(WIDE_BITS-4){1'b0}}, cp_offset};
        step_overflow = (scaled[WIDE_BITS-1:VALUE_BITS] != 4'd0);
        consumed_bumped = (consumed_reg == {COUNT_BITS{1'b1}})
                          ? consumed_reg : consumed_reg + 1'b1;
    end

    // range check against the selected width
    always_comb begin
        unique case (width_code_reg)
            WIDTH_8:  umax = {{(VALUE_BITS-8){1'b0}},  {8{1'b1}}};
            WIDTH_16: umax = {{(VALUE_BITS-16){1'b0}}, {16{1'b1}}};
            WIDTH_32: umax = {{(VALUE_BITS-32){1'b0}}, {32{1'b1}}};
            WIDTH_64: umax = {VALUE_BITS{1'b1}};
            default:  umax = {VALUE_BITS{1'b1}};
        endcase
        smax  = umax >> 1;
        value = '0;
        if (phase_reg != PHASE_DIGITS) begin
            status = STATUS_NO_DIGITS;
        end else if (overflow_reg || (magnitude_reg > umax)) begin
            status = STATUS_RANGE;
        end else if (!minus_reg) begin
            if (is_signed_reg && (magnitude_reg > smax)) begin
                status = STATUS_RANGE;
            end else begin
                status = STATUS_OK;
                value  = magnitude_reg;
            end
        end else if (!is_signed_reg) begin
            // negative zero is fine unsigned
            status = (magnitude_reg == '0) ? STATUS_OK : STATUS_RANGE;
        end else if (magnitude_reg > smax + 1'b1) begin
            status = STATUS_RANGE;
        end else begin
            status = STATUS_OK;
            value  = '0 - magnitude_reg;
        end

        out_data_next.value_bits         = value;
        out_data_next.status             = status;
        out_data_next.consumed_count     = (status == STATUS_OK)
                                           ? COUNT_OUT_BITS'(consumed_reg)
                                           : '0;
        out_data_next.terminator         = eoi ? '0 : cp;
        out_data_next.ended_by_input_end = eoi;
    end

    // next parse state
    always_comb begin
        phase_next     = phase_reg;
        minus_next     = minus_reg;
        magnitude_next = magnitude_reg;
        overflow_next  = overflow_reg;
        consumed_next  = consumed_reg;
        if (take_item) begin
            if (closes) begin
                phase_next     = PHASE_START;
                minus_next     = 1'b0;
                magnitude_next = '0;
                overflow_next  = 1'b0;
                consumed_next  = '0;
            end else if (is_digit) begin
                phase_next    = PHASE_DIGITS;
                consumed_next = consumed_bumped;
                if (step_overflow) begin
                    overflow_next = 1'b1;
                end else begin
                    magnitude_next = scaled[VALUE_BITS-1:0];
                end
            end else begin
                phase_next    = PHASE_SIGN;
                minus_next    = (cp == CP_MINUS);
                consumed_next = consumed_bumped;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PHASE_START;
            minus_reg     <= 1'b0;
            magnitude_reg <= '0;
            overflow_reg  <= 1'b0;
            consumed_reg  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (take_item) begin
                in_valid_reg <= 1'b0;
            end
            if (take_item && closes) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            phase_reg     <= phase_next;
            minus_reg     <= minus_next;
            magnitude_reg <= magnitude_next;
            overflow_reg  <= overflow_next;
            consumed_reg  <= consumed_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (take_item && closes) begin
            out_data_reg <= out_data_next;
        end
    end

    // errors carry neither value nor count
    a_error_zeroed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != STATUS_OK))
        |-> ((m_data.value_bits == '0) && (m_data.consumed_count == '0)))
        else $error("error result with nonzero value or count");

    // a number never closes on a digit
    a_term_not_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.ended_by_input_end)
        |-> ((m_data.terminator < CP_ZERO) || (m_data.terminator > CP_NINE)))
        else $error("digit reported as terminator");

    // end of input reports a zero terminator
    a_eoi_term_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.ended_by_input_end) |-> (m_data.terminator == '0))
        else $error("nonzero terminator at end of input");

    // the start phase holds a cleared accumulator
    a_start_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PHASE_START)
        |-> ((magnitude_reg == '0) && (consumed_reg == '0) && !overflow_reg && !minus_reg))
        else $error("stale parse state in start phase");

    // a closing item held back by a stalled result stays in the input stage
    a_close_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && closes && out_valid_reg && !m_ready)
        |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("closing item lost while the output stalled");

endmodule
